// File: sv/lshs_pkg.sv
// ----------------------------------------------------------------------------
// lshs_pkg
// Types, widths and codes shared by the limit-switch homing sequencer.
// ----------------------------------------------------------------------------
package lshs_pkg;

    // Field widths
    localparam int unsigned PosW    = 32;
    localparam int unsigned VelW    = 16;
    localparam int unsigned CountW  = 8;
    localparam int unsigned ActionW = 2;
    localparam int unsigned CfgAddrW = 2;
    localparam int unsigned CfgDataW = 16;

    // Stream data widths, padded to whole bytes
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 40;

    // Wait counter saturation value
    localparam logic [CountW-1:0] WaitMax = '1;

    // Reset values of the configuration registers
    localparam logic [VelW-1:0]   VelRst    = '0;
    localparam logic [CountW-1:0] ThreshRst = 8'd3;
    localparam logic              PolRst    = 1'b0;

    // Item kinds carried on tuser
    typedef enum logic [ActionW-1:0] {
        ACT_TICK    = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Configuration register indexes
    typedef enum logic [CfgAddrW-1:0] {
        CFG_VELOCITY  = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_POLARITY  = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_addr_t;

    // Homing phases
    typedef enum logic [1:0] {
        PH_INIT = 2'd0,
        PH_POS  = 2'd1,
        PH_NEG  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

endpackage

// File: sv/limit_switch_homing_sequencer_top.sv
// ----------------------------------------------------------------------------
// limit_switch_homing_sequencer_top
// Debounced limit-switch homing sequencer: one result item per input item.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tuser: action; tdata: switch_level, preset_pos
//  m_axis   | out       | tdata: setpoint_pos, homing_done, homing_restart
//  cfg      | in        | write-only: velocity, debounce threshold, polarity
//
//  An item passes through the input register and then the result register;
//  one item per cycle is sustained while m_axis is not stalled.
//  Reset clears the state to INIT, zero counts and zero position.
//  A stalled result register holds the input register, which then stalls s_axis.
// ----------------------------------------------------------------------------
module limit_switch_homing_sequencer_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    // stream in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lshs_pkg::InDataW-1:0]       s_tdata,   // [0] switch_level, [32:1] preset_pos
    input  logic [lshs_pkg::ActionW-1:0]       s_tuser,   // [1:0] action
    // stream out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lshs_pkg::OutDataW-1:0]      m_tdata,   // [31:0] setpoint_pos, [32] homing_done,
                                                          // [33] homing_restart
    // configuration
    input  logic                               cfg_we,
    input  logic [lshs_pkg::CfgAddrW-1:0]      cfg_addr,
    input  logic [lshs_pkg::CfgDataW-1:0]      cfg_wdata
);

    localparam int unsigned PosW   = lshs_pkg::PosW;
    localparam int unsigned CountW = lshs_pkg::CountW;
    localparam int unsigned VelW   = lshs_pkg::VelW;

    // Configuration registers
    logic [VelW-1:0]   velocity_reg;
    logic [CountW-1:0] threshold_reg;
    logic              polarity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_reg  <= lshs_pkg::VelRst;
            threshold_reg <= lshs_pkg::ThreshRst;
            polarity_reg  <= lshs_pkg::PolRst;
        end
        else if (cfg_we)
        begin
            unique case (lshs_pkg::cfg_addr_t'(cfg_addr))
                lshs_pkg::CFG_VELOCITY:  velocity_reg  <= cfg_wdata[VelW-1:0];
                lshs_pkg::CFG_THRESHOLD: threshold_reg <= cfg_wdata[CountW-1:0];
                lshs_pkg::CFG_POLARITY:  polarity_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Handshake between input register and result register
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Input payload register
    lshs_pkg::action_t  in_action_reg;
    logic               in_level_reg;
    logic [PosW-1:0]    in_start_reg;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg <= lshs_pkg::action_t'(s_tuser);
            in_level_reg  <= s_tdata[0];
            in_start_reg  <= s_tdata[PosW:1];
        end
    end

    // Sequencer state
    lshs_pkg::phase_t  phase_reg, phase_next;
    logic [CountW-1:0] level_count_reg, level_count_next;
    logic [CountW-1:0] wait_count_reg, wait_count_next;
    logic [PosW-1:0]   position_reg, position_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= lshs_pkg::PH_INIT;
            level_count_reg <= '0;
            wait_count_reg  <= '0;
            position_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            level_count_reg <= level_count_next;
            wait_count_reg  <= wait_count_next;
            position_reg    <= position_next;
        end
    end

    // Debounce counter on a tick
    logic [CountW-1:0] sampled_count;
    logic              count_at_thresh;

    always_comb
    begin
        if (in_level_reg == polarity_reg)
            sampled_count = (level_count_reg >= threshold_reg) ? threshold_reg
                                                               : level_count_reg + 1'b1;
        else
            sampled_count = (level_count_reg != '0) ? level_count_reg - 1'b1
                                                    : level_count_reg;
        count_at_thresh = (sampled_count >= threshold_reg);
    end

    // Next state
    logic [CountW-1:0] wait_inc;
    logic [PosW-1:0]   velocity_ext;

    assign wait_inc     = (wait_count_reg < lshs_pkg::WaitMax) ? wait_count_reg + 1'b1
                                                               : wait_count_reg;
    assign velocity_ext = {{(PosW-VelW){1'b0}}, velocity_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        level_count_next = level_count_reg;
        wait_count_next  = wait_count_reg;
        position_next    = position_reg;
        unique case (in_action_reg)
            lshs_pkg::ACT_TICK:
            begin
                level_count_next = sampled_count;
                unique case (phase_reg)
                    lshs_pkg::PH_INIT:
                    begin
                        wait_count_next = wait_inc;
                        if (wait_inc >= threshold_reg)
                            phase_next = count_at_thresh ? lshs_pkg::PH_POS
                                                         : lshs_pkg::PH_NEG;
                    end
                    lshs_pkg::PH_POS:
                    begin
                        position_next = position_reg + velocity_ext;
                        if (sampled_count == '0)
                            phase_next = lshs_pkg::PH_NEG;
                    end
                    lshs_pkg::PH_NEG:
                    begin
                        position_next = position_reg - velocity_ext;
                        if (count_at_thresh)
                            phase_next = lshs_pkg::PH_DONE;
                    end
                    default: ;
                endcase
            end
            lshs_pkg::ACT_LOAD:
                position_next = in_start_reg;
            lshs_pkg::ACT_RESTART:
            begin
                phase_next       = lshs_pkg::PH_INIT;
                level_count_next = '0;
                wait_count_next  = '0;
            end
            default: ;
        endcase
    end

    // Outputs from the updated phase
    logic done_flag;
    logic restart_flag;

    always_comb
    begin
        done_flag    = (phase_next == lshs_pkg::PH_DONE);
        restart_flag = (phase_next == lshs_pkg::PH_INIT);
    end

    // Result register
    logic [PosW-1:0] out_pos_reg;
    logic            out_done_reg;
    logic            out_restart_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pos_reg     <= position_next;
            out_done_reg    <= done_flag;
            out_restart_reg <= restart_flag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lshs_pkg::OutDataW-PosW-2){1'b0}},
                       out_restart_reg, out_done_reg, out_pos_reg};

`ifndef SYNTH
    // A processed item always lands in the result register
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item did not reach result register");

    // A held input item is not dropped while the output stalls
    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg)
        else $error("input item lost during stall");

    // DONE is left only by a restart
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == lshs_pkg::PH_DONE && in_action_reg != lshs_pkg::ACT_RESTART
        |=> phase_reg == lshs_pkg::PH_DONE)
        else $error("left DONE without restart");

    // Done and restart flags never both set
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_done_reg && out_restart_reg))
        else $error("done and restart both set");
`endif

endmodule
